@@ rtl/rlef_pkg.sv @@
`default_nettype none

package rlef_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned NumCodesDef   = 16;

  localparam logic [15:0] MinIntervalRst = 16'd100;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RAISE = 2'd1,
    KIND_POP   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

endpackage

`default_nettype wire

@@ rtl/rate_limited_error_fifo_unit.sv @@
`default_nettype none

// Error event queue with a per-code rate limit. Each input item is a
// millisecond tick, a raise of an error code, a pop of the oldest entry or a no-op,
// and each produces one result with the accept/drop flags and the queue head and
// count after the item. A raise passes when the wrapped 32-bit difference of
// the time counter and the code's last passing time is strictly above
// min_interval_ms; the timestamp is refreshed even when a full queue drops
// the raise. All codes start with a last time of zero. Each item has an accept
// cycle, which reads the timestamp and queue memories (synchronous read); the
// next cycle modifies, writes back and loads the output register. Timestamp
// entries carry valid bits, so no clearing pass runs after reset.
module rate_limited_error_fifo_unit #(
  parameter int unsigned QUEUE_DEPTH = rlef_pkg::QueueDepthDef,
  parameter int unsigned NUM_CODES   = rlef_pkg::NumCodesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [3:0]  error_code_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             accepted_o,
  output logic             dropped_full_o,
  output logic             head_valid_o,
  output logic [3:0]       head_code_o,
  output logic [4:0]       count_o
);

  localparam int unsigned QAW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CAW  = $clog2(NUM_CODES);
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);

  // control state
  rlef_pkg::state_e     state_q, state_d;
  logic [QAW-1:0]       rp_q, rp_d;
  logic [QAW-1:0]       wp_q, wp_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;
  logic [31:0]          now_q, now_d;
  logic [15:0]          min_q;
  logic [NUM_CODES-1:0] ts_vld_q;
  logic                 out_valid_q;

  // item payload and memory read data
  rlef_pkg::kind_e      kind_q;
  logic [3:0]           code_q;
  logic [31:0]          ts_rdata_q;
  logic [3:0]           q_rdata_q;

  logic                 accepted_q, dropped_q, head_valid_q;
  logic [3:0]           head_code_q;
  logic [CNTW-1:0]      cnt_out_q;

  logic [3:0]           q_mem  [QUEUE_DEPTH];
  logic [31:0]          ts_mem [NUM_CODES];

  logic                 in_acc;
  logic                 exec;
  logic [QAW-1:0]       rp_inc, wp_inc, q_raddr;
  logic [CAW-1:0]       ts_raddr, ts_idx;
  logic                 code_ok;
  logic [31:0]          last_time, age;
  logic                 pass, full, acc, drop, do_pop, ts_we;
  logic [3:0]           head_code;

  assign in_stall_o = !((state_q == rlef_pkg::ST_IDLE) && (!out_valid_q || !out_stall_i));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign exec       = (state_q == rlef_pkg::ST_EXEC);

  assign rp_inc = (rp_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + QAW'(1);
  assign wp_inc = (wp_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + QAW'(1);

  // a pop reports the entry behind the current head
  assign q_raddr  = (rlef_pkg::kind_e'(kind_i) == rlef_pkg::KIND_POP) ? rp_inc : rp_q;
  assign ts_raddr = CAW'(error_code_i);
  assign ts_idx   = CAW'(code_q);

  assign code_ok   = ({5'd0, code_q} < 9'(NUM_CODES));
  assign last_time = ts_vld_q[ts_idx] ? ts_rdata_q : 32'd0;
  assign age       = now_q - last_time;
  assign full      = (cnt_q == CNTW'(QUEUE_DEPTH));

  always_comb begin
    pass   = 1'b0;
    do_pop = 1'b0;
    now_d  = now_q;
    unique case (kind_q)
      rlef_pkg::KIND_TICK:  now_d  = now_q + 32'd1;
      rlef_pkg::KIND_RAISE: pass   = code_ok && (age > {16'd0, min_q});
      rlef_pkg::KIND_POP:   do_pop = (cnt_q != '0);
      rlef_pkg::KIND_NONE:  ;
      default:              ;
    endcase
  end

  assign acc   = pass && !full;
  assign drop  = pass && full;
  assign ts_we = exec && pass;

  always_comb begin
    rp_d  = rp_q;
    wp_d  = wp_q;
    cnt_d = cnt_q;
    if (acc) begin
      wp_d  = wp_inc;
      cnt_d = cnt_q + CNTW'(1);
    end
    if (do_pop) begin
      rp_d  = rp_inc;
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  // forward the code just written when it lands in an empty queue
  always_comb begin
    if (cnt_d == '0) begin
      head_code = 4'd0;
    end else if ((cnt_q == '0) && acc) begin
      head_code = code_q;
    end else begin
      head_code = q_rdata_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rlef_pkg::ST_IDLE: if (in_acc) state_d = rlef_pkg::ST_EXEC;
      rlef_pkg::ST_EXEC: state_d = rlef_pkg::ST_IDLE;
      default:           state_d = rlef_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlef_pkg::ST_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      cnt_q       <= '0;
      now_q       <= '0;
      min_q       <= rlef_pkg::MinIntervalRst;
      ts_vld_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) min_q <= cfg_wdata_i;
      if (exec) begin
        rp_q  <= rp_d;
        wp_q  <= wp_d;
        cnt_q <= cnt_d;
        now_q <= now_d;
      end
      if (ts_we) ts_vld_q[ts_idx] <= 1'b1;
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= rlef_pkg::kind_e'(kind_i);
      code_q <= error_code_i;
    end
    if (exec) begin
      accepted_q   <= acc;
      dropped_q    <= drop;
      head_valid_q <= (cnt_d != '0);
      head_code_q  <= head_code;
      cnt_out_q    <= cnt_d;
    end
  end

  // memories: read in the accept cycle, write back in the execute cycle
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ts_rdata_q <= ts_mem[ts_raddr];
      q_rdata_q  <= q_mem[q_raddr];
    end
    if (ts_we) ts_mem[ts_idx] <= now_q;
    if (exec && acc) q_mem[wp_q] <= code_q;
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = accepted_q;
  assign dropped_full_o = dropped_q;
  assign head_valid_o   = head_valid_q;
  assign head_code_o    = head_code_q;
  assign count_o        = 5'(cnt_out_q);

  a_exec_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |-> !out_valid_q)
    else $error("result computed while output register busy");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> exec)
    else $error("accepted item did not reach execute");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_head_matches_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (head_valid_q == (cnt_q != '0)))
    else $error("reported head valid disagrees with queue count");

  a_acc_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && pass |-> (acc != drop))
    else $error("passing raise neither stored nor dropped");

endmodule

`default_nettype wire
